FILE: hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared wrappers for clocked concurrent assertions in the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks prop at every rising edge of clk outside of reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error(msg);

// Checks that cond at one edge implies conseq at the next edge.
`define ASSERT_NEXT(label, cond, conseq, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (conseq)) \
    else $error(msg);

`endif

FILE: hw/rtl/msod_pkg.sv
// ---------------------------------------------------------------------------
// ModRM/SIB operand decoder package
// Codes, limits and field types shared by the operand decoder.
// ---------------------------------------------------------------------------
package msod_pkg;

  localparam int unsigned MAX_INSN_LENGTH = 15;

  localparam logic [1:0] OP_LEA   = 2'd0;
  localparam logic [1:0] OP_WRITE = 2'd1;
  localparam logic [1:0] OP_LOAD  = 2'd2;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_TRUNC = 2'd1;
  localparam logic [1:0] ST_UNSUP = 2'd2;

  localparam logic [7:0] OPC_STORE_BYTE = 8'h88;
  localparam logic [7:0] OPC_LOAD_BYTE  = 8'h8a;

  localparam logic [1:0] MOD_NODISP = 2'd0;
  localparam logic [1:0] MOD_DISP8  = 2'd1;
  localparam logic [1:0] MOD_DISP32 = 2'd2;
  localparam logic [1:0] MOD_REG    = 2'd3;

  localparam logic [2:0] RM_SIB      = 3'd4;
  localparam logic [2:0] RM_DISP32   = 3'd5;
  localparam logic [2:0] SIB_NO_IDX  = 3'd4;
  localparam logic [2:0] SIB_NO_BASE = 3'd5;

  localparam logic [4:0] NO_REG = 5'd16;

  localparam int unsigned IN_TDATA_W  = 72;
  localparam int unsigned OUT_TDATA_W = 64;

  typedef struct packed {
    logic [7:0]  opcode_byte;
    logic [3:0]  rex_bits;
    logic        operand_size_16;
    logic        address_size_32;
    logic [47:0] window;
    logic [3:0]  bytes_available;
    logic [3:0]  bytes_used;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  consumed;
    logic [3:0]  reg_number;
    logic        high_byte_reg;
    logic [3:0]  operand_width;
    logic [4:0]  base_reg;
    logic [4:0]  index_reg;
    logic [1:0]  scale_log2;
    logic        pc_relative;
    logic [31:0] displacement;
  } out_item_t;

endpackage

FILE: hw/rtl/modrm_sib_operand_decoder.sv
// Throughput: one item per cycle unless out_tready stalls the output; an input
// register feeds the decode logic, whose answer lands in the output register.
// Reset: rst_n is synchronous and active low; it empties both registers.
// ---------------------------------------------------------------------------
// ModRM/SIB operand decoder
// Decodes the ModRM, SIB and displacement bytes of one x86-64 instruction.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module modrm_sib_operand_decoder (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // opcode_byte, rex_bits, operand_size_16, address_size_32, window,
  // bytes_available, bytes_used, zero padding
  input  logic [msod_pkg::IN_TDATA_W-1:0]  in_tdata,
  // op
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // consumed, reg_number, high_byte_reg, operand_width, base_reg, index_reg,
  // scale_log2, pc_relative, displacement, zero padding
  output logic [msod_pkg::OUT_TDATA_W-1:0] out_tdata,
  // status
  output logic [1:0]  out_tuser
);

  localparam logic [4:0] MAX_LEN = 5'(msod_pkg::MAX_INSN_LENGTH);

  logic                 s1_valid_r;
  logic [1:0]           s1_op_r;
  msod_pkg::in_item_t   s1_item_r;
  logic                 out_valid_r;
  logic [1:0]           out_status_r;
  msod_pkg::out_item_t  out_item_r;

  logic                 out_load;
  logic                 in_xfer;
  msod_pkg::in_item_t   in_item;

  logic [1:0]           mod_f;
  logic [2:0]           rm_f;
  logic [2:0]           raw_reg;
  logic [2:0]           sib_base;
  logic [2:0]           sib_index;
  logic                 has_sib;
  logic                 no_base_sib;
  logic [2:0]           dsize;
  logic [4:0]           pos;
  logic [4:0]           avail5;
  logic [4:0]           used5;
  logic                 byte_op;
  logic [31:0]          disp8_x;
  logic [31:0]          disp32_x;
  logic [1:0]           status_nxt;
  msod_pkg::out_item_t  item_nxt;

  logic                 out_fail;
  logic                 out_ok;
  logic                 out_pcrel;
  logic                 out_no_regs;

  assign in_item  = msod_pkg::in_item_t'({in_tdata[7:0], in_tdata[11:8], in_tdata[12],
                                          in_tdata[13], in_tdata[61:14], in_tdata[65:62],
                                          in_tdata[69:66]});
  assign out_load  = !out_valid_r || out_tready;
  assign in_tready = !s1_valid_r || out_load;
  assign in_xfer   = in_tvalid && in_tready;

  always_comb begin
    mod_f       = s1_item_r.window[7:6];
    rm_f        = s1_item_r.window[2:0];
    raw_reg     = s1_item_r.window[5:3];
    sib_base    = s1_item_r.window[10:8];
    sib_index   = s1_item_r.window[13:11];
    has_sib     = (rm_f == msod_pkg::RM_SIB);
    no_base_sib = has_sib && (mod_f == msod_pkg::MOD_NODISP)
                  && (sib_base == msod_pkg::SIB_NO_BASE);
    avail5      = {1'b0, s1_item_r.bytes_available};
    used5       = {1'b0, s1_item_r.bytes_used};
    pos         = has_sib ? 5'd2 : 5'd1;

    if (mod_f == msod_pkg::MOD_DISP8) begin
      dsize = 3'd1;
    end else if (mod_f == msod_pkg::MOD_DISP32) begin
      dsize = 3'd4;
    end else if (no_base_sib || (!has_sib && rm_f == msod_pkg::RM_DISP32)) begin
      dsize = 3'd4;
    end else begin
      dsize = 3'd0;
    end

    disp8_x  = has_sib ? {{24{s1_item_r.window[23]}}, s1_item_r.window[23:16]}
                       : {{24{s1_item_r.window[15]}}, s1_item_r.window[15:8]};
    disp32_x = has_sib ? s1_item_r.window[47:16] : s1_item_r.window[39:8];

    byte_op = (s1_op_r == msod_pkg::OP_WRITE)
              ? (s1_item_r.opcode_byte == msod_pkg::OPC_STORE_BYTE)
              : (s1_item_r.opcode_byte == msod_pkg::OPC_LOAD_BYTE);

    item_nxt.consumed      = pos[2:0] + dsize;
    item_nxt.reg_number    = {s1_item_r.rex_bits[2], raw_reg};
    item_nxt.high_byte_reg = 1'b0;
    item_nxt.scale_log2    = has_sib ? s1_item_r.window[15:14] : 2'd0;
    item_nxt.pc_relative   = !has_sib && (mod_f == msod_pkg::MOD_NODISP)
                             && (rm_f == msod_pkg::RM_DISP32) && !s1_item_r.address_size_32;
    if (has_sib && (sib_index != msod_pkg::SIB_NO_IDX || s1_item_r.rex_bits[1])) begin
      item_nxt.index_reg = {1'b0, s1_item_r.rex_bits[1], sib_index};
    end else begin
      item_nxt.index_reg = msod_pkg::NO_REG;
    end
    if (has_sib) begin
      item_nxt.base_reg = no_base_sib ? msod_pkg::NO_REG
                                      : {1'b0, s1_item_r.rex_bits[0], sib_base};
    end else if (mod_f == msod_pkg::MOD_NODISP && rm_f == msod_pkg::RM_DISP32) begin
      item_nxt.base_reg = msod_pkg::NO_REG;
    end else begin
      item_nxt.base_reg = {1'b0, s1_item_r.rex_bits[0], rm_f};
    end
    if (dsize == 3'd1) begin
      item_nxt.displacement = disp8_x;
    end else if (dsize == 3'd4) begin
      item_nxt.displacement = disp32_x;
    end else begin
      item_nxt.displacement = 32'd0;
    end

    if (s1_op_r == msod_pkg::OP_LEA) begin
      item_nxt.operand_width = s1_item_r.rex_bits[3] ? 4'd8 : 4'd4;
    end else begin
      if (byte_op) begin
        item_nxt.operand_width = 4'd1;
      end else if (s1_item_r.rex_bits[3]) begin
        item_nxt.operand_width = 4'd8;
      end else if (s1_item_r.operand_size_16) begin
        item_nxt.operand_width = 4'd2;
      end else begin
        item_nxt.operand_width = 4'd4;
      end
      if (byte_op && s1_item_r.rex_bits == 4'd0 && raw_reg[2]) begin
        item_nxt.reg_number    = {2'b00, raw_reg[1:0]};
        item_nxt.high_byte_reg = 1'b1;
      end
    end

    if (s1_op_r != msod_pkg::OP_LEA && s1_op_r != msod_pkg::OP_WRITE
        && s1_op_r != msod_pkg::OP_LOAD) begin
      status_nxt = msod_pkg::ST_UNSUP;
    end else if (s1_op_r == msod_pkg::OP_LEA && s1_item_r.operand_size_16) begin
      status_nxt = msod_pkg::ST_UNSUP;
    end else if (avail5 == 5'd0) begin
      status_nxt = msod_pkg::ST_TRUNC;
    end else if (s1_op_r != msod_pkg::OP_LEA && mod_f == msod_pkg::MOD_REG) begin
      status_nxt = msod_pkg::ST_UNSUP;
    end else if (used5 >= MAX_LEN) begin
      status_nxt = msod_pkg::ST_TRUNC;
    end else if (mod_f == msod_pkg::MOD_REG) begin
      status_nxt = msod_pkg::ST_UNSUP;
    end else if (has_sib && (avail5 <= 5'd1 || used5 + 5'd1 >= MAX_LEN)) begin
      status_nxt = msod_pkg::ST_TRUNC;
    end else if (pos + {2'b00, dsize} > avail5
                 || used5 + pos + {2'b00, dsize} > MAX_LEN) begin
      status_nxt = msod_pkg::ST_TRUNC;
    end else begin
      status_nxt = msod_pkg::ST_OK;
    end

    if (status_nxt != msod_pkg::ST_OK) begin
      item_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_tready) begin
        s1_valid_r <= in_tvalid;
      end
      if (out_load) begin
        out_valid_r <= s1_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_xfer) begin
      s1_op_r   <= in_tuser;
      s1_item_r <= in_item;
    end
    if (out_load && s1_valid_r) begin
      out_status_r <= status_nxt;
      out_item_r   <= item_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tuser  = out_status_r;
  assign out_tdata  = {7'd0, out_item_r.displacement, out_item_r.pc_relative,
                       out_item_r.scale_log2, out_item_r.index_reg, out_item_r.base_reg,
                       out_item_r.operand_width, out_item_r.high_byte_reg,
                       out_item_r.reg_number, out_item_r.consumed};

  assign out_fail    = out_valid_r && (out_status_r != msod_pkg::ST_OK);
  assign out_ok      = out_valid_r && (out_status_r == msod_pkg::ST_OK);
  assign out_pcrel   = out_valid_r && out_item_r.pc_relative;
  assign out_no_regs = (out_item_r.base_reg == msod_pkg::NO_REG)
                       && (out_item_r.index_reg == msod_pkg::NO_REG);

  `ASSERT_CLK(a_fail_zero, out_fail |-> out_item_r == '0, "failed decode carries nonzero fields")
  `ASSERT_CLK(a_ok_consumed, out_ok |-> out_item_r.consumed != 3'd0, "decode consumed no bytes")
  `ASSERT_CLK(a_pcrel_no_regs, out_pcrel |-> out_no_regs, "RIP-relative operand has a base or index")
  `ASSERT_NEXT(a_in_captured, in_tvalid && in_tready, s1_valid_r, "input transfer was not captured")
  `ASSERT_NEXT(a_out_from_s1, s1_valid_r && out_load, out_valid_r, "decoded item was not registered")

endmodule

FILE: verif/modrm_sib_operand_decoder_tb.sv
// ---------------------------------------------------------------------------
// ModRM/SIB operand decoder testbench
// Sends operand-decode requests through the input stream and checks every
// decoded result against a table entry or a behavioral decoder. A short
// directed table comes first, then mostly well-formed random encodings with
// some noise, under changing amounts of sender and receiver idling.
// ---------------------------------------------------------------------------
module modrm_sib_operand_decoder_tb;

  localparam logic [1:0] OP_ADDR = msod_pkg::OP_LEA;
  localparam logic [1:0] OP_WR   = msod_pkg::OP_WRITE;
  localparam logic [1:0] OP_RD   = msod_pkg::OP_LOAD;
  localparam logic [1:0] OP_BAD  = 2'd3;
  localparam logic [1:0] S_OK    = msod_pkg::ST_OK;
  localparam logic [1:0] S_TRUNC = msod_pkg::ST_TRUNC;
  localparam logic [1:0] S_UNSUP = msod_pkg::ST_UNSUP;
  localparam int ITEMS_PER_PHASE = 600;
  localparam int QUIET_LIMIT = 2000;
  localparam int PRINT_LIMIT = 100;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  opcode_byte;
    logic [3:0]  rex_bits;
    logic        operand_size_16;
    logic        address_size_32;
    logic [47:0] window;
    logic [3:0]  bytes_available;
    logic [3:0]  bytes_used;
  } operand_item_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [2:0]  consumed;
    logic [3:0]  reg_number;
    logic        high_byte_reg;
    logic [3:0]  operand_width;
    logic [4:0]  base_reg;
    logic [4:0]  index_reg;
    logic [1:0]  scale_log2;
    logic        pc_relative;
    logic [31:0] displacement;
  } decode_result_t;

  typedef struct packed {
    operand_item_t item;
    logic          typed;
    logic [1:0]    status;
  } directed_row_t;

  localparam directed_row_t DIRECTED_ROWS [24] = '{
    '{'{OP_ADDR, 8'h8d, 4'h0, 1'b1, 1'b0, 48'h000000000005, 4'd15, 4'd0},  1'b1, S_UNSUP},
    '{'{OP_ADDR, 8'h8d, 4'h0, 1'b0, 1'b0, 48'h000000000005, 4'd0,  4'd0},  1'b1, S_TRUNC},
    '{'{OP_ADDR, 8'h8d, 4'h0, 1'b0, 1'b0, 48'h000000000000, 4'd15, 4'd15}, 1'b1, S_TRUNC},
    '{'{OP_ADDR, 8'h8d, 4'h8, 1'b0, 1'b0, 48'h0000000000c0, 4'd6,  4'd0},  1'b1, S_UNSUP},
    '{'{OP_WR,   8'h89, 4'h0, 1'b0, 1'b0, 48'h0000000000c0, 4'd0,  4'd0},  1'b1, S_TRUNC},
    '{'{OP_WR,   8'h89, 4'h0, 1'b0, 1'b0, 48'h0000000000c0, 4'd15, 4'd15}, 1'b1, S_UNSUP},
    '{'{OP_RD,   8'h8b, 4'h0, 1'b0, 1'b0, 48'h000000000000, 4'd15, 4'd15}, 1'b1, S_TRUNC},
    '{'{OP_BAD,  8'h8b, 4'h0, 1'b0, 1'b0, 48'h000000000000, 4'd15, 4'd0},  1'b1, S_UNSUP},
    '{'{OP_ADDR, 8'h8d, 4'h0, 1'b0, 1'b0, 48'h000000002404, 4'd1,  4'd0},  1'b1, S_TRUNC},
    '{'{OP_ADDR, 8'h8d, 4'h0, 1'b0, 1'b0, 48'h000000002404, 4'd15, 4'd14}, 1'b1, S_TRUNC},
    '{'{OP_RD,   8'h8b, 4'h0, 1'b0, 1'b0, 48'h000012345680, 4'd4,  4'd0},  1'b1, S_TRUNC},
    '{'{OP_RD,   8'h8b, 4'h0, 1'b0, 1'b0, 48'h000000007f40, 4'd2,  4'd14}, 1'b1, S_TRUNC},
    '{'{OP_ADDR, 8'h8d, 4'h0, 1'b0, 1'b0, 48'h000000002004, 4'd2,  4'd0},  1'b0, S_OK},
    '{'{OP_ADDR, 8'h8d, 4'h2, 1'b0, 1'b0, 48'h000000002004, 4'd2,  4'd0},  1'b0, S_OK},
    '{'{OP_ADDR, 8'h8d, 4'h0, 1'b0, 1'b0, 48'h87654321e504, 4'd6,  4'd0},  1'b0, S_OK},
    '{'{OP_ADDR, 8'h8d, 4'h0, 1'b0, 1'b0, 48'h00fffffff005, 4'd5,  4'd0},  1'b0, S_OK},
    '{'{OP_ADDR, 8'h8d, 4'h0, 1'b0, 1'b1, 48'h00fffffff005, 4'd5,  4'd0},  1'b0, S_OK},
    '{'{OP_WR,   8'h88, 4'h0, 1'b0, 1'b0, 48'h000000000020, 4'd1,  4'd0},  1'b0, S_OK},
    '{'{OP_WR,   8'h88, 4'h4, 1'b0, 1'b0, 48'h000000000038, 4'd1,  4'd0},  1'b0, S_OK},
    '{'{OP_RD,   8'h8a, 4'h0, 1'b0, 1'b0, 48'h000000008068, 4'd2,  4'd0},  1'b0, S_OK},
    '{'{OP_RD,   8'h8b, 4'h0, 1'b1, 1'b0, 48'h00ddccbbaa91, 4'd5,  4'd10}, 1'b0, S_OK},
    '{'{OP_ADDR, 8'h8d, 4'hf, 1'b0, 1'b0, 48'hffffffffffbc, 4'd15, 4'd9},  1'b0, S_OK},
    '{'{OP_RD,   8'h00, 4'h0, 1'b0, 1'b0, 48'h000000000000, 4'd1,  4'd0},  1'b0, S_OK},
    '{'{OP_WR,   8'hff, 4'h8, 1'b1, 1'b1, 48'h0000007f244c, 4'd3,  4'd12}, 1'b0, S_OK}
  };

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [71:0] in_tdata;
  logic [1:0]  in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [63:0] out_tdata;
  logic [1:0]  out_tuser;

  decode_result_t expected_decodes[$];
  int mismatch_count = 0;
  int src_gap_pct = 0;
  int dst_stall_pct = 0;

  modrm_sib_operand_decoder dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic decode_result_t rejected_result(input logic [1:0] status);
    decode_result_t r;
    r = '0;
    r.status = status;
    return r;
  endfunction

  function automatic decode_result_t decode_operand(input operand_item_t it);
    decode_result_t r;
    logic [7:0] sib;
    logic [1:0] md;
    logic [2:0] rm;
    logic [2:0] raw;
    logic       byte_op;
    int         avail;
    int         used;
    int         lim;
    int         pos;
    int         dsize;
    r = '0;
    md = it.window[7:6];
    raw = it.window[5:3];
    rm = it.window[2:0];
    avail = it.bytes_available;
    used = it.bytes_used;
    lim = msod_pkg::MAX_INSN_LENGTH;
    if (it.op == OP_BAD) begin
      return rejected_result(S_UNSUP);
    end
    if (it.op == OP_ADDR) begin
      if (it.operand_size_16) return rejected_result(S_UNSUP);
    end else begin
      if (avail == 0) return rejected_result(S_TRUNC);
      if (md == msod_pkg::MOD_REG) return rejected_result(S_UNSUP);
    end
    if (avail == 0 || used >= lim) return rejected_result(S_TRUNC);
    if (md == msod_pkg::MOD_REG) return rejected_result(S_UNSUP);

    pos = 1;
    dsize = 0;
    r.base_reg = msod_pkg::NO_REG;
    r.index_reg = msod_pkg::NO_REG;
    if (rm == msod_pkg::RM_SIB) begin
      if (pos >= avail || used + pos >= lim) return rejected_result(S_TRUNC);
      sib = it.window[15:8];
      pos = 2;
      r.scale_log2 = sib[7:6];
      if (sib[5:3] != msod_pkg::SIB_NO_IDX || it.rex_bits[1]) begin
        r.index_reg = {1'b0, it.rex_bits[1], sib[5:3]};
      end
      if (md == msod_pkg::MOD_NODISP && sib[2:0] == msod_pkg::SIB_NO_BASE) begin
        dsize = 4;
      end else begin
        r.base_reg = {1'b0, it.rex_bits[0], sib[2:0]};
      end
    end else if (md == msod_pkg::MOD_NODISP && rm == msod_pkg::RM_DISP32) begin
      r.pc_relative = !it.address_size_32;
      dsize = 4;
    end else begin
      r.base_reg = {1'b0, it.rex_bits[0], rm};
    end
    if (md == msod_pkg::MOD_DISP8) dsize = 1;
    if (md == msod_pkg::MOD_DISP32) dsize = 4;
    if (dsize > avail - pos || dsize > lim - (used + pos)) return rejected_result(S_TRUNC);
    for (int k = 0; k < dsize; k++) begin
      r.displacement[8*k +: 8] = it.window[8*(pos+k) +: 8];
    end
    if (dsize == 1) r.displacement[31:8] = {24{r.displacement[7]}};
    pos += dsize;

    r.status = S_OK;
    r.consumed = 3'(pos);
    r.reg_number = {it.rex_bits[2], raw};
    if (it.op == OP_ADDR) begin
      r.operand_width = it.rex_bits[3] ? 4'd8 : 4'd4;
    end else begin
      byte_op = (it.op == OP_WR) ? (it.opcode_byte == msod_pkg::OPC_STORE_BYTE)
                                 : (it.opcode_byte == msod_pkg::OPC_LOAD_BYTE);
      r.operand_width = byte_op ? 4'd1 : it.rex_bits[3] ? 4'd8 :
                        it.operand_size_16 ? 4'd2 : 4'd4;
      if (byte_op && it.rex_bits == 4'd0 && raw >= 3'd4) begin
        r.reg_number = {1'b0, raw - 3'd4};
        r.high_byte_reg = 1'b1;
      end
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    if (mismatch_count < PRINT_LIMIT) begin
      $display("%0t: mismatch in %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    end
    mismatch_count++;
  endtask

  task automatic drive_item(input operand_item_t it, input decode_result_t want);
    while ($urandom_range(99) < src_gap_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {2'b00, it.bytes_used, it.bytes_available, it.window, it.address_size_32,
                 it.operand_size_16, it.rex_bits, it.opcode_byte};
    in_tuser <= it.op;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_decodes.push_back(want);
  endtask

  task automatic wait_drained();
    in_tvalid <= 1'b0;
    while (expected_decodes.size() != 0) @(posedge clk);
  endtask

  initial begin
    out_tready <= 1'b0;
    forever begin
      @(posedge clk);
      out_tready <= ($urandom_range(99) >= dst_stall_pct);
    end
  end

  always @(posedge clk) begin : result_check
    decode_result_t got;
    decode_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.status = out_tuser;
      got.consumed = out_tdata[2:0];
      got.reg_number = out_tdata[6:3];
      got.high_byte_reg = out_tdata[7];
      got.operand_width = out_tdata[11:8];
      got.base_reg = out_tdata[16:12];
      got.index_reg = out_tdata[21:17];
      got.scale_log2 = out_tdata[23:22];
      got.pc_relative = out_tdata[24];
      got.displacement = out_tdata[56:25];
      if (expected_decodes.size() == 0) begin
        report_mismatch("result transfer with none expected, status", 32'(got.status), 32'd0);
      end else begin
        want = expected_decodes.pop_front();
        if (got.status != want.status)
          report_mismatch("status", 32'(got.status), 32'(want.status));
        if (got.consumed != want.consumed)
          report_mismatch("consumed", 32'(got.consumed), 32'(want.consumed));
        if (got.reg_number != want.reg_number)
          report_mismatch("reg_number", 32'(got.reg_number), 32'(want.reg_number));
        if (got.high_byte_reg != want.high_byte_reg)
          report_mismatch("high_byte_reg", 32'(got.high_byte_reg), 32'(want.high_byte_reg));
        if (got.operand_width != want.operand_width)
          report_mismatch("operand_width", 32'(got.operand_width), 32'(want.operand_width));
        if (got.base_reg != want.base_reg)
          report_mismatch("base_reg", 32'(got.base_reg), 32'(want.base_reg));
        if (got.index_reg != want.index_reg)
          report_mismatch("index_reg", 32'(got.index_reg), 32'(want.index_reg));
        if (got.scale_log2 != want.scale_log2)
          report_mismatch("scale_log2", 32'(got.scale_log2), 32'(want.scale_log2));
        if (got.pc_relative != want.pc_relative)
          report_mismatch("pc_relative", 32'(got.pc_relative), 32'(want.pc_relative));
        if (got.displacement != want.displacement)
          report_mismatch("displacement", got.displacement, want.displacement);
      end
    end
  end

  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
        quiet = 0;
      end else begin
        quiet++;
      end
    end
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  initial begin : stimulus
    operand_item_t  it;
    logic [1:0]     md;
    logic [2:0]     rm;
    int             need;
    int             roll;
    rst_n <= 1'b0;
    in_tvalid <= 1'b0;
    in_tdata <= '0;
    in_tuser <= OP_ADDR;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    src_gap_pct = 25;
    dst_stall_pct = 58;
    foreach (DIRECTED_ROWS[i]) begin
      drive_item(DIRECTED_ROWS[i].item,
                 DIRECTED_ROWS[i].typed ? rejected_result(DIRECTED_ROWS[i].status)
                                        : decode_operand(DIRECTED_ROWS[i].item));
    end
    // The sender holds off here until every decode has come back.
    wait_drained();

    for (int phase = 0; phase < 3; phase++) begin
      src_gap_pct = (phase == 0) ? 25 : (phase == 1) ? 58 : 0;
      dst_stall_pct = (phase == 0) ? 58 : (phase == 1) ? 25 : 0;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
        it.window[47:16] = $urandom;
        it.window[15:0] = 16'($urandom);
        roll = $urandom_range(99);
        it.op = (roll < 3) ? OP_BAD : (roll < 35) ? OP_ADDR : (roll < 68) ? OP_WR : OP_RD;
        if ($urandom_range(2) == 0) begin
          it.opcode_byte = (it.op == OP_WR) ? msod_pkg::OPC_STORE_BYTE
                                            : msod_pkg::OPC_LOAD_BYTE;
        end else begin
          it.opcode_byte = 8'($urandom);
        end
        it.rex_bits = ($urandom_range(2) == 0) ? 4'd0 : 4'($urandom);
        it.operand_size_16 = (it.op == OP_ADDR) ? ($urandom_range(9) == 0)
                                                : 1'($urandom_range(1));
        it.address_size_32 = 1'($urandom_range(1));
        md = ($urandom_range(19) == 0) ? msod_pkg::MOD_REG : 2'($urandom_range(2));
        rm = ($urandom_range(3) == 0) ? msod_pkg::RM_SIB :
             ($urandom_range(3) == 0) ? msod_pkg::RM_DISP32 : 3'($urandom);
        it.window[7:6] = md;
        it.window[2:0] = rm;
        if ($urandom_range(3) == 0) it.window[10:8] = msod_pkg::SIB_NO_BASE;
        if ($urandom_range(3) == 0) it.window[13:11] = msod_pkg::SIB_NO_IDX;
        need = (rm == msod_pkg::RM_SIB) ? 2 : 1;
        if (md == msod_pkg::MOD_DISP8) begin
          need += 1;
        end else if (md == msod_pkg::MOD_DISP32) begin
          need += 4;
        end else if (md == msod_pkg::MOD_NODISP &&
                     (rm == msod_pkg::RM_DISP32 ||
                      (rm == msod_pkg::RM_SIB && it.window[10:8] == msod_pkg::SIB_NO_BASE))) begin
          need += 4;
        end
        // Most encodings fit both the window and the length limit.
        if ($urandom_range(9) < 8) begin
          it.bytes_available = 4'($urandom_range(15, need));
          it.bytes_used = 4'($urandom_range(15 - need, 0));
        end else begin
          it.bytes_available = 4'($urandom_range(15));
          it.bytes_used = 4'($urandom_range(15));
        end
        drive_item(it, decode_operand(it));
      end
      wait_drained();
    end

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && expected_decodes.size() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

FILE: filelist.f
+incdir+hw/rtl
hw/rtl/msod_pkg.sv
hw/rtl/modrm_sib_operand_decoder.sv
verif/modrm_sib_operand_decoder_tb.sv
